>>> design/dhtis_pkg.sv
// Package for the double-hash table insert/search unit.
// Holds field widths, operation and status codes and the table entry type.
// No dependencies.
`default_nettype none

package dhtis_pkg;

   localparam int KEY_W    = 10;
   localparam int DEST_W   = 32;
   localparam int HOUR_W   = 4;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // one table slot as stored in memory
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [DEST_W-1:0] dest;
      logic [HOUR_W-1:0] hour;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

>>> design/dhtis_req_if.sv
// Request channel interface: operation, key and entry payload.
// Depends on dhtis_pkg.
`default_nettype none

interface dhtis_req_if
   import dhtis_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [KEY_W-1:0]  flight_key;
   logic [DEST_W-1:0] dest_code;
   logic [HOUR_W-1:0] depart_hour;

   modport source (output valid, operation, flight_key, dest_code, depart_hour,
                   input ready);
   modport sink   (input valid, operation, flight_key, dest_code, depart_hour,
                   output ready);
endinterface

`default_nettype wire

>>> design/dhtis_rsp_if.sv
// Response channel interface: status, slot and found entry payload.
// Depends on dhtis_pkg.
`default_nettype none

interface dhtis_rsp_if
   import dhtis_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_index;
   logic [DEST_W-1:0]   found_dest;
   logic [HOUR_W-1:0]   found_hour;

   modport source (output valid, status, slot_index, found_dest, found_hour,
                   input ready);
   modport sink   (input valid, status, slot_index, found_dest, found_hour,
                    output ready);
endinterface

`default_nettype wire

>>> design/dhtis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dhtis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

>>> design/double_hash_table_insert_search_unit.sv
// Steps: key div size; then the start slot and the second quotient; then
// the probe step and the first read; then 1 to TABLE_SIZE probed slots;
// then the result is registered. Throughput: the single table read port,
// one probe per cycle, sets it; a result waits in S_DONE while the output
// register is full. Next item taken while the result waits in the output
// register. Reset: synchronous; a clearing pass writes all TABLE_SIZE slots
// empty, one per cycle, and no request is taken until it ends.
`default_nettype none

module double_hash_table_insert_search_unit
   import dhtis_pkg::*;
#(
   parameter int TABLE_SIZE = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   dhtis_req_if.sink   req_bus,
   dhtis_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W:0]   SIZE_C = (IDX_W+1)'(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_C = IDX_W'(TABLE_SIZE - 1);

   // division by the table size through a reciprocal multiply, exact for
   // every KEY_W-bit dividend
   localparam int RECIP_W = KEY_W + 1;
   localparam int PROD_W  = KEY_W + RECIP_W;
   localparam int DIV_SH  = KEY_W + IDX_W;
   localparam logic [RECIP_W-1:0] RECIP_C =
      RECIP_W'(((1 << DIV_SH) + TABLE_SIZE - 1) / TABLE_SIZE);
   localparam logic [KEY_W:0] SIZE_K_C = (KEY_W+1)'(TABLE_SIZE);

   typedef enum logic [6:0] {
      S_CLEAR   = 7'b0000001,
      S_IDLE    = 7'b0000010,
      S_DIV_KEY = 7'b0000100,
      S_DIV_QUO = 7'b0001000,
      S_READ    = 7'b0010000,
      S_CHECK   = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // request capture
   logic              op_ff,   op_in;
   logic [KEY_W-1:0]  key_ff,  key_in;
   logic [DEST_W-1:0] dest_ff, dest_in;
   logic [HOUR_W-1:0] hour_ff, hour_in;

   // quotients and remainders by the table size
   logic [KEY_W-1:0]  div_ff, div_in;
   logic [KEY_W-1:0]  quo_ff, quo_in;
   logic [PROD_W-1:0] key_prod;
   logic [PROD_W-1:0] div_prod;
   logic [KEY_W-1:0]  key_quo;
   logic [KEY_W-1:0]  div_quo;
   logic [IDX_W-1:0]  key_rem;
   logic [IDX_W-1:0]  div_rem;

   // probe state
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] tries_ff, tries_in;
   logic [IDX_W:0]   idx_sum;
   logic [IDX_W:0]   idx_sum_sub;
   logic [IDX_W-1:0] idx_next;
   logic [IDX_W+SLOT_W-1:0] idx_ext;

   // pending result and output register
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_slot_ff,   res_slot_in;
   logic [DEST_W-1:0]   res_dest_ff,   res_dest_in;
   logic [HOUR_W-1:0]   res_hour_ff,   res_hour_in;
   logic                out_valid_ff,  out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [SLOT_W-1:0]   out_slot_ff,   out_slot_in;
   logic [DEST_W-1:0]   out_dest_ff,   out_dest_in;
   logic [HOUR_W-1:0]   out_hour_ff,   out_hour_in;

   // memory ports
   logic             ram_we;
   logic [IDX_W-1:0] ram_rd_addr;
   entry_type        ram_wr_entry;
   entry_type        ram_rd_entry;
   logic [ENTRY_W-1:0] ram_rd_data;

   dhtis_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_table (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (idx_ff),
      .write_data    (ram_wr_entry),
      .read_address  (ram_rd_addr),
      .read_data     (ram_rd_data)
   );

   assign ram_rd_entry = entry_type'(ram_rd_data);

   // quotients by reciprocal multiply, remainders by multiply back and subtract
   assign key_prod = PROD_W'(key_ff) * PROD_W'(RECIP_C);
   assign key_quo  = KEY_W'(key_prod >> DIV_SH);
   assign div_prod = PROD_W'(div_ff) * PROD_W'(RECIP_C);
   assign div_quo  = KEY_W'(div_prod >> DIV_SH);
   assign key_rem  = IDX_W'({1'b0, key_ff} - ({1'b0, div_ff} * SIZE_K_C));
   assign div_rem  = IDX_W'({1'b0, div_ff} - ({1'b0, quo_ff} * SIZE_K_C));

   // next probe slot, sum stays below twice the size
   assign idx_sum     = {1'b0, idx_ff} + {1'b0, step_ff};
   assign idx_sum_sub = idx_sum - SIZE_C;
   assign idx_next    = (idx_sum >= SIZE_C) ? idx_sum_sub[IDX_W-1:0]
                                            : idx_sum[IDX_W-1:0];
   assign idx_ext     = {{SLOT_W{1'b0}}, idx_ff};

   assign req_bus.ready = (state_ff == S_IDLE);

   // sequencer and datapath next values
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      dest_in       = dest_ff;
      hour_in       = hour_ff;
      div_in        = div_ff;
      quo_in        = quo_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      tries_in      = tries_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_dest_in   = res_dest_ff;
      res_hour_in   = res_hour_ff;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_dest_in   = out_dest_ff;
      out_hour_in   = out_hour_ff;
      out_valid_in  = out_valid_ff;
      ram_we        = 1'b0;
      ram_rd_addr   = idx_ff;
      ram_wr_entry  = '{valid: 1'b1, key: key_ff, dest: dest_ff, hour: hour_ff};

      // drop the output once transferred
      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            // sweep every slot empty
            ram_we       = 1'b1;
            ram_wr_entry = '0;
            idx_in       = idx_ff + 1'b1;
            if (idx_ff == LAST_C) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.operation;
               key_in   = req_bus.flight_key;
               dest_in  = req_bus.dest_code;
               hour_in  = req_bus.depart_hour;
               state_in = S_DIV_KEY;
            end
         end
         S_DIV_KEY: begin
            // key div size
            div_in   = key_quo;
            state_in = S_DIV_QUO;
         end
         S_DIV_QUO: begin
            // key mod size gives the start slot; take the second quotient
            idx_in   = key_rem;
            quo_in   = div_quo;
            state_in = S_READ;
         end
         S_READ: begin
            // issue the read of the start slot; a zero step becomes one
            ram_rd_addr = idx_ff;
            step_in     = (div_rem == '0) ? IDX_W'(1) : div_rem;
            tries_in    = '0;
            state_in    = S_CHECK;
         end
         S_CHECK: begin
            // examine the slot read last cycle, prefetch the next one
            ram_rd_addr   = idx_next;
            res_slot_in   = '0;
            res_dest_in   = '0;
            res_hour_in   = '0;
            if (op_ff == OP_INSERT) begin
               if (!ram_rd_entry.valid) begin
                  ram_we        = 1'b1;
                  res_status_in = ST_INSERTED;
                  res_slot_in   = idx_ext[SLOT_W-1:0];
                  state_in      = S_DONE;
               end else if (tries_ff == LAST_C) begin
                  res_status_in = ST_FULL;
                  state_in      = S_DONE;
               end else begin
                  idx_in   = idx_next;
                  tries_in = tries_ff + 1'b1;
               end
            end else begin
               if (!ram_rd_entry.valid) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else if (ram_rd_entry.key == key_ff) begin
                  res_status_in = ST_FOUND;
                  res_slot_in   = idx_ext[SLOT_W-1:0];
                  res_dest_in   = ram_rd_entry.dest;
                  res_hour_in   = ram_rd_entry.hour;
                  state_in      = S_DONE;
               end else if (tries_ff == LAST_C) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_DONE;
               end else begin
                  idx_in   = idx_next;
                  tries_in = tries_ff + 1'b1;
               end
            end
         end
         S_DONE: begin
            // hand the result to the output register when it is free
            if (!out_valid_ff || rsp_bus.ready) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_slot_in   = res_slot_ff;
               out_dest_in   = res_dest_ff;
               out_hour_in   = res_hour_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      dest_ff       <= dest_in;
      hour_ff       <= hour_in;
      div_ff        <= div_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      tries_ff      <= tries_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_dest_ff   <= res_dest_in;
      res_hour_ff   <= res_hour_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_dest_ff   <= out_dest_in;
      out_hour_ff   <= out_hour_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.status     = out_status_ff;
   assign rsp_bus.slot_index = out_slot_ff;
   assign rsp_bus.found_dest = out_dest_ff;
   assign rsp_bus.found_hour = out_hour_ff;

   // an insert never overwrites an occupied slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && ram_we) |-> !ram_rd_entry.valid)
      else $error("insert wrote an occupied slot");

   // the probe step is nonzero and inside the table while probing
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (step_ff != '0 && {1'b0, step_ff} < SIZE_C))
      else $error("probe step out of range");

   // the probe slot stays inside the table
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> ({1'b0, idx_ff} < SIZE_C))
      else $error("probe slot out of range");

   // a finished result moves into a free output register
   a_done_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !out_valid_ff) |=> (out_valid_ff && state_ff == S_IDLE))
      else $error("result not loaded into free output register");

endmodule

`default_nettype wire

>>> tb/sv/double_hash_table_insert_search_unit_test.sv
// Self-checking testbench for the double-hash table insert/search unit.
// Drives insert and search requests, predicts every response, compares per field.
// Depends on dhtis_pkg, dhtis_req_if, dhtis_rsp_if and the unit itself.
`default_nettype none

module double_hash_table_insert_search_unit_test;
   import dhtis_pkg::*;

   localparam int TABLE_SIZE  = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 60;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [DEST_W-1:0]   dest;
      logic [HOUR_W-1:0]   hour;
   } lookup_result_type;

   logic clock;
   logic reset;

   dhtis_req_if flight_req ();
   dhtis_rsp_if flight_rsp ();

   double_hash_table_insert_search_unit #(
      .TABLE_SIZE (TABLE_SIZE)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (flight_req),
      .rsp_bus (flight_rsp)
   );

   // shadow copy of the table
   logic              table_used [TABLE_SIZE];
   logic [KEY_W-1:0]  table_key  [TABLE_SIZE];
   logic [DEST_W-1:0] table_dest [TABLE_SIZE];
   logic [HOUR_W-1:0] table_hour [TABLE_SIZE];

   lookup_result_type pending_results[$];
   logic [KEY_W-1:0]  stored_keys[$];
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   int                req_max_gap    = 4;
   int                rsp_max_gap    = 4;
   int                rsp_hold_cycles = 0;

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Stop a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("double_hash_table_insert_search_unit_test failed");
      $finish;
   end

   // Probe the shadow table the way the unit does, update it, return the response.
   function automatic lookup_result_type predict_table_op(logic op, logic [KEY_W-1:0] key,
                                                           logic [DEST_W-1:0] dest,
                                                           logic [HOUR_W-1:0] hour);
      lookup_result_type res;
      int                idx;
      int                stride;
      bit                done;
      idx    = key % TABLE_SIZE;
      stride = (key / TABLE_SIZE) % TABLE_SIZE;
      done   = 1'b0;
      if (stride == 0)
         stride = 1;
      res = '{status: (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND,
              slot: '0, dest: '0, hour: '0};
      for (int tries = 0; tries < TABLE_SIZE; tries++) begin
         if (!done) begin
            if (op == OP_INSERT) begin
               if (!table_used[idx]) begin
                  table_used[idx] = 1'b1;
                  table_key[idx]  = key;
                  table_dest[idx] = dest;
                  table_hour[idx] = hour;
                  res = '{status: ST_INSERTED, slot: idx[SLOT_W-1:0], dest: '0, hour: '0};
                  done = 1'b1;
               end
            end else begin
               if (!table_used[idx]) begin
                  res  = '{status: ST_NOT_FOUND, slot: '0, dest: '0, hour: '0};
                  done = 1'b1;
               end else if (table_key[idx] == key) begin
                  res = '{status: ST_FOUND, slot: idx[SLOT_W-1:0],
                          dest: table_dest[idx], hour: table_hour[idx]};
                  done = 1'b1;
               end
            end
            idx = (idx + stride) % TABLE_SIZE;
         end
      end
      return res;
   endfunction

   // Offer one request after a random gap, hold it until the transfer, record the prediction.
   task automatic send_table_op(logic op, logic [KEY_W-1:0] key,
                                logic [DEST_W-1:0] dest, logic [HOUR_W-1:0] hour);
      int                gap;
      lookup_result_type res;
      gap = $urandom_range(0, req_max_gap);
      @(negedge clock);
      if (gap > 0) begin
         flight_req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      flight_req.valid       <= 1'b1;
      flight_req.operation   <= op;
      flight_req.flight_key  <= key;
      flight_req.dest_code   <= dest;
      flight_req.depart_hour <= hour;
      do
         @(posedge clock);
      while (!flight_req.ready);
      res = predict_table_op(op, key, dest, hour);
      pending_results.push_back(res);
      if (op == OP_INSERT && res.status == ST_INSERTED)
         stored_keys.push_back(key);
   endtask

   // Response side: random stalls, an optional long hold-off, compare each transfer.
   initial begin
      int                gap;
      lookup_result_type want;
      flight_rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            flight_rsp.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(negedge clock);
            rsp_hold_cycles = 0;
         end
         gap = $urandom_range(0, rsp_max_gap);
         if (gap > 0) begin
            flight_rsp.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         flight_rsp.ready <= 1'b1;
         do
            @(posedge clock);
         while (!flight_rsp.valid);
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response status=%0d slot=%0d dest=%h hour=%0d",
                     $time, flight_rsp.status, flight_rsp.slot_index,
                     flight_rsp.found_dest, flight_rsp.found_hour);
         end else begin
            want = pending_results.pop_front();
            if (flight_rsp.status !== want.status) begin
               mismatch_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, flight_rsp.status);
            end
            if (flight_rsp.slot_index !== want.slot) begin
               mismatch_count++;
               $display("%0t: slot_index expected %0d actual %0d",
                        $time, want.slot, flight_rsp.slot_index);
            end
            if (flight_rsp.found_dest !== want.dest) begin
               mismatch_count++;
               $display("%0t: found_dest expected %h actual %h",
                        $time, want.dest, flight_rsp.found_dest);
            end
            if (flight_rsp.found_hour !== want.hour) begin
               mismatch_count++;
               $display("%0t: found_hour expected %0d actual %0d",
                        $time, want.hour, flight_rsp.found_hour);
            end
         end
      end
   end

   // Random request: mostly searches of stored keys, inserts with some duplicate keys.
   task automatic send_random_op();
      logic              op;
      logic [KEY_W-1:0]  key;
      logic [HOUR_W-1:0] hour;
      op   = ($urandom_range(0, 99) < 35) ? OP_INSERT : OP_SEARCH;
      key  = KEY_W'($urandom_range(0, (1 << KEY_W) - 1));
      hour = HOUR_W'($urandom_range(0, (1 << HOUR_W) - 1));
      if (stored_keys.size() > 0 && $urandom_range(0, 99) < ((op == OP_SEARCH) ? 60 : 25))
         key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      send_table_op(op, key, $urandom, hour);
   endtask

   // Collisions, zero stride, duplicates, probe limits and field extremes.
   task automatic test_directed_probes();
      send_table_op(OP_SEARCH, 10'd0,    32'h0000_0000, 4'd0);   // empty table
      send_table_op(OP_INSERT, 10'd0,    32'h0000_0000, 4'd0);   // zero stride
      send_table_op(OP_INSERT, 10'd16,   32'h1234_5678, 4'd5);   // collides with key 0
      send_table_op(OP_INSERT, 10'd0,    32'hFFFF_FFFF, 4'd15);  // duplicate key
      send_table_op(OP_SEARCH, 10'd0,    32'hFFFF_FFFF, 4'd15);  // first match wins
      send_table_op(OP_SEARCH, 10'd16,   32'h0000_0000, 4'd0);
      send_table_op(OP_INSERT, 10'd1023, 32'hFFFF_FFFF, 4'd11);
      send_table_op(OP_SEARCH, 10'd1023, 32'h5555_5555, 4'd7);
      send_table_op(OP_SEARCH, 10'd32,   32'h0000_0000, 4'd0);   // ends at empty slot
      send_table_op(OP_INSERT, 10'd132,  32'hA5A5_A5A5, 4'd12);  // stride 8
      send_table_op(OP_INSERT, 10'd132,  32'h5A5A_5A5A, 4'd13);
      send_table_op(OP_INSERT, 10'd900,  32'hDEAD_BEEF, 4'd14);  // both stride-8 slots taken
      send_table_op(OP_SEARCH, 10'd388,  32'h0000_0000, 4'd0);   // probe limit, no match
      send_table_op(OP_SEARCH, 10'd132,  32'h0000_0000, 4'd0);
      send_table_op(OP_INSERT, 10'd513,  32'h8000_0001, 4'd1);
      send_table_op(OP_SEARCH, 10'd513,  32'h0000_0000, 4'd0);
      send_table_op(OP_SEARCH, 10'd1022, 32'hFFFF_FFFF, 4'd15);
   endtask

   // Hold the response side off while requests keep coming, so the unit backs up.
   task automatic test_response_backpressure();
      req_max_gap     = 0;
      rsp_hold_cycles = 400;
      repeat (20) send_random_op();
      req_max_gap = 4;
   endtask

   // Random traffic, with a stretch of no idling on either side.
   task automatic test_random_traffic();
      repeat (1000) send_random_op();
      req_max_gap = 0;
      rsp_max_gap = 0;
      repeat (200) send_random_op();
      req_max_gap = 4;
      rsp_max_gap = 4;
      repeat (180) send_random_op();
   endtask

   // Sequence: reset, tests, drain, verdict.
   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         table_used[i] = 1'b0;
         table_key[i]  = '0;
         table_dest[i] = '0;
         table_hour[i] = '0;
      end
      reset                  = 1'b1;
      flight_req.valid       = 1'b0;
      flight_req.operation   = OP_INSERT;
      flight_req.flight_key  = '0;
      flight_req.dest_code   = '0;
      flight_req.depart_hour = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_probes();
      test_response_backpressure();
      test_random_traffic();

      @(negedge clock);
      flight_req.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("double_hash_table_insert_search_unit_test passed");
      else
         $display("double_hash_table_insert_search_unit_test failed");
      $finish;
   end

endmodule

`default_nettype wire
